@@ rtl/rtc_counter_match_interrupt_defines.svh @@
// Assertion macros shared by the RTC counter RTL files.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef RTC_COUNTER_MATCH_INTERRUPT_DEFINES_SVH
`define RTC_COUNTER_MATCH_INTERRUPT_DEFINES_SVH
`ifndef SYNTHESIS
// check on every edge outside reset
`define RCMI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check on every edge, reset included
`define RCMI_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCMI_ASSERT(name, prop, msg)
`define RCMI_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

@@ rtl/rcmi_pkg.sv @@
// Package for the RTC counter with match interrupt: codes, bit positions, item types.
// No dependencies; used by the interfaces, the register file and the top level.
package rcmi_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int ACT_W           = 2;
  localparam int OFF_W           = 3;
  localparam int CTL_W           = 4;

  localparam logic [DATA_W-1:0] VERSION_WORD = 32'h3230_332a;

  // control bit positions
  localparam int CTL_WRAP = 3;
  localparam int CTL_EN   = 2;
  localparam int CTL_MASK = 1;
  localparam int CTL_IEN  = 0;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_t;

  typedef enum logic [OFF_W-1:0] {
    OFF_COUNT   = 3'd0,
    OFF_MATCH   = 3'd1,
    OFF_LOAD    = 3'd2,
    OFF_CONTROL = 3'd3,
    OFF_STATUS  = 3'd4,
    OFF_RAW     = 3'd5,
    OFF_EOI     = 3'd6,
    OFF_VERSION = 3'd7
  } reg_offset_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [OFF_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_value;
  } item_t;

  typedef struct packed {
    logic              fire;
    item_t             item;
  } step_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              irq_line;
  } result_t;

endpackage

@@ rtl/rcmi_if.sv @@
// Valid/ready channel interfaces for the RTC counter: request beats and result beats.
// Depends on rcmi_pkg for field widths.
interface rcmi_in_if;
  import rcmi_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [OFF_W-1:0]  reg_offset;
  logic [DATA_W-1:0] write_value;

  modport source (output valid, output action, output reg_offset, output write_value,
                  input ready);
  modport sink   (input valid, input action, input reg_offset, input write_value,
                  output ready);
endinterface

interface rcmi_out_if;
  import rcmi_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_value;
  logic              irq_line;

  modport source (output valid, output read_value, output irq_line, input ready);
  modport sink   (input valid, input read_value, input irq_line, output ready);
endinterface

@@ rtl/rtc_counter_match_interrupt.sv @@
// Top level of the RTC counter with match interrupt: input stage, register file, result stage.
// Depends on rcmi_pkg, rcmi_if and rcmi_regfile.
//
//   channel   dir   beat contents                        handshake
//   in_bus    in    action, reg_offset, write_value      valid/ready
//   out_bus   out   read_value, irq_line                 valid/ready
//
// One beat per clock sustained while out_bus is ready; requests and results are registered.
// The request register feeds the register file; its single-pass update sets the rate.
// A held result stalls the request stage only; one more request still lands behind it.
// Synchronous active-low reset clears both stage valid flags and the register file state.
`include "rtc_counter_match_interrupt_defines.svh"
module rtc_counter_match_interrupt #(
  parameter int COUNT_WIDTH = rcmi_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rcmi_in_if.sink           in_bus,
  rcmi_out_if.source        out_bus
);
  import rcmi_pkg::*;

  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t res;
  step_t   step;
  logic    out_free;
  logic    s1_adv;
  logic    in_fire;

  assign out_free      = !out_valid_r || out_bus.ready;
  assign s1_adv        = s1_valid_r && out_free;
  assign in_bus.ready  = !s1_valid_r || s1_adv;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_bus.ready);

  assign step.fire = s1_adv;
  assign step.item = s1_item_r;

  rcmi_regfile #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.action      <= in_bus.action;
      s1_item_r.reg_offset  <= in_bus.reg_offset;
      s1_item_r.write_value <= in_bus.write_value;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.read_value = out_res_r.read_value;
  assign out_bus.irq_line   = out_res_r.irq_line;

  `RCMI_ASSERT(a_stall_only_when_full, !in_bus.ready |-> s1_valid_r && out_valid_r,
               "request side stalled with room left")
  `RCMI_ASSERT(a_stage_drains, s1_valid_r && !out_valid_r |=> out_valid_r,
               "request stage did not move into a free result stage")
  `RCMI_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !s1_valid_r && !out_valid_r,
                      "reset left a stage occupied")

endmodule

@@ rtl/rcmi_regfile.sv @@
// Counter, match, load and control registers with the raw interrupt flag.
// Applies one request beat per step and returns its result; depends on rcmi_pkg.
`include "rtc_counter_match_interrupt_defines.svh"
module rcmi_regfile #(
  parameter int COUNT_WIDTH = rcmi_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rcmi_pkg::step_t   step,
  output rcmi_pkg::result_t result
);
  import rcmi_pkg::*;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [COUNT_WIDTH-1:0] match_r, match_nxt;
  logic [COUNT_WIDTH-1:0] load_r, load_nxt;
  logic [CTL_W-1:0]       ctl_r, ctl_nxt;
  logic                   raw_r, raw_nxt;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [DATA_W-1:0]      rdata;

  assign count_inc = count_r + COUNT_WIDTH'(1);
  assign wdata     = COUNT_WIDTH'(step.item.write_value);

  always_comb begin
    count_nxt = count_r;
    match_nxt = match_r;
    load_nxt  = load_r;
    ctl_nxt   = ctl_r;
    raw_nxt   = raw_r;
    rdata     = '0;
    if (step.fire) begin
      unique case (step.item.action)
        ACT_TICK: begin
          if (ctl_r[CTL_EN]) begin
            count_nxt = count_inc;
            if (count_inc == match_r && ctl_r[CTL_IEN]) begin
              raw_nxt = 1'b1;
              if (ctl_r[CTL_WRAP]) begin
                count_nxt = '0;
              end
            end
          end
        end
        ACT_READ: begin
          unique case (reg_offset_t'(step.item.reg_offset))
            OFF_COUNT:   rdata = DATA_W'(count_r);
            OFF_MATCH:   rdata = DATA_W'(match_r);
            OFF_LOAD:    rdata = DATA_W'(load_r);
            OFF_CONTROL: rdata = DATA_W'(ctl_r);
            OFF_STATUS:  rdata = DATA_W'(raw_r && !ctl_r[CTL_MASK]);
            OFF_RAW:     rdata = DATA_W'(raw_r);
            OFF_EOI:     raw_nxt = 1'b0;
            OFF_VERSION: rdata = VERSION_WORD;
          endcase
        end
        ACT_WRITE: begin
          unique case (reg_offset_t'(step.item.reg_offset))
            OFF_MATCH: match_nxt = wdata;
            OFF_LOAD: begin
              load_nxt  = wdata;
              count_nxt = wdata;
            end
            OFF_CONTROL: begin
              ctl_nxt = step.item.write_value[CTL_W-1:0];
              if (!step.item.write_value[CTL_EN]) begin
                raw_nxt = 1'b0;
              end
            end
            OFF_COUNT, OFF_STATUS, OFF_RAW, OFF_EOI, OFF_VERSION: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign result.read_value = rdata;
  assign result.irq_line   = raw_nxt && !ctl_nxt[CTL_MASK];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      match_r <= '0;
      load_r  <= '0;
      ctl_r   <= '0;
      raw_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      match_r <= match_nxt;
      load_r  <= load_nxt;
      ctl_r   <= ctl_nxt;
      raw_r   <= raw_nxt;
    end
  end

  `RCMI_ASSERT(a_disable_clears_flag, step.fire && step.item.action == ACT_WRITE && step.item.reg_offset == OFF_CONTROL && !step.item.write_value[CTL_EN] |=> !raw_r, "control write without enable left the flag set")
  `RCMI_ASSERT(a_eoi_clears_flag, step.fire && step.item.action == ACT_READ && step.item.reg_offset == OFF_EOI |=> !raw_r, "end-of-interrupt read left the flag set")
  `RCMI_ASSERT(a_wrap_restarts, step.fire && step.item.action == ACT_TICK && ctl_r == CTL_W'(4'hf) && count_inc == match_r |=> count_r == '0 && raw_r, "match with wrap did not restart the count")
  `RCMI_ASSERT(a_idle_holds, !step.fire |=> $stable(count_r) && $stable(raw_r) && $stable(ctl_r), "state moved without a beat")

endmodule
